/* hdl/dsso_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dsso_pkg;

    // Decimal digits an 8-bit value can need.
    localparam int unsigned SEG_DIGITS = 3;

    // Queue between front and back.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    // Segment byte of the digit 0 (a in bit 7, dp in bit 0).
    localparam logic [7:0] SEG_ZERO = 8'hFC;

    typedef struct packed {
        logic                           mode;
        logic [SEG_DIGITS-1:0][7:0]     seg;   // [0] ones, [1] tens, [2] hundreds
    } t_entry;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] pattern;
        unique case (digit)
            4'd0:    pattern = SEG_ZERO;
            4'd1:    pattern = 8'h60;
            4'd2:    pattern = 8'hDA;
            4'd3:    pattern = 8'hF2;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'hB6;
            4'd6:    pattern = 8'hBE;
            4'd7:    pattern = 8'hE0;
            4'd8:    pattern = 8'hFE;
            4'd9:    pattern = 8'hF6;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage
`default_nettype wire

/* hdl/dsso_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// In show mode saturates the value, splits it into decimal digits and maps
// them to segment bytes (all zero in clear mode); the result is pushed into the queue.
module dsso_front #(
    parameter int unsigned DIGITS = 2
) (
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_mode,
    input  wire logic [7:0]       i_value,
    input  wire logic             i_full,
    output logic                  o_push,
    output dsso_pkg::t_entry      o_entry
);

    // Display limit 10^DIGITS; from three digits on no 8-bit value reaches it.
    localparam logic [8:0] LIMIT = (DIGITS == 1) ? 9'd10 :
                                   (DIGITS == 2) ? 9'd100 : 9'd256;
    localparam logic [7:0] MAX_SHOWN = 8'(LIMIT - 9'd1);

    logic [7:0]  sat;
    logic [1:0]  hundreds;
    logic [6:0]  rest;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [6:0]  tens_x10;

    always_comb begin
        sat = ({1'b0, i_value} >= LIMIT) ? MAX_SHOWN : i_value;

        priority if (sat >= 8'd200) begin
            hundreds = 2'd2;
            rest     = 7'(sat - 8'd200);
        end else if (sat >= 8'd100) begin
            hundreds = 2'd1;
            rest     = 7'(sat - 8'd100);
        end else begin
            hundreds = 2'd0;
            rest     = sat[6:0];
        end

        // rest / 10 by reciprocal, exact for rest < 100
        prod     = 15'(rest) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        ones     = 4'(rest - tens_x10);

        o_entry.mode = i_mode;
        if (i_mode) begin
            o_entry.seg = '0;
        end else begin
            o_entry.seg[0] = dsso_pkg::seg_of(ones);
            o_entry.seg[1] = dsso_pkg::seg_of(tens);
            o_entry.seg[2] = dsso_pkg::seg_of({2'b00, hundreds});
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule
`default_nettype wire

/* hdl/dsso_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue of classified items between front and back.
module dsso_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire dsso_pkg::t_entry   i_entry,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output dsso_pkg::t_entry        o_entry
);

    dsso_pkg::t_entry                  r_mem [dsso_pkg::Q_DEPTH];
    logic [dsso_pkg::Q_PTR_W-1:0]      r_wr_ptr;
    logic [dsso_pkg::Q_PTR_W-1:0]      r_rd_ptr;
    logic [dsso_pkg::Q_CNT_W-1:0]      r_count;
    logic [dsso_pkg::Q_CNT_W-1:0]      n_count;

    assign o_full  = (r_count == dsso_pkg::Q_CNT_W'(dsso_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

/* hdl/dsso_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Serializer: one frame bit per transfer, ones digit first, LSB first.
module dsso_back #(
    parameter int unsigned DIGITS = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire dsso_pkg::t_entry   i_q_entry,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_serial_data,
    output logic [2:0]              o_bit_position,
    output logic                    o_last_bit
);

    localparam int unsigned TOTAL = 8 * DIGITS;
    localparam int unsigned CNT_W = $clog2(TOTAL);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TOTAL - 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    dsso_pkg::t_entry   r_entry;
    logic               r_out_valid;
    logic               r_data;
    logic [2:0]         r_pos;
    logic               r_last;

    dsso_pkg::t_entry   src;
    logic [TOTAL-1:0]   frame;
    logic [CNT_W-1:0]   cnt_cur;
    logic               adv;
    logic               emit;
    logic               at_last;

    always_comb begin
        src     = r_busy ? r_entry : i_q_entry;
        cnt_cur = r_busy ? r_cnt : '0;
        adv     = !r_out_valid || !i_stall;
        emit    = adv && (r_busy || i_q_valid);
        at_last = (cnt_cur == LAST);
    end

    // Digits beyond what an 8-bit value needs show 0, or blank when clearing.
    for (genvar g = 0; g < DIGITS; g++) begin : g_byte
        if (g < dsso_pkg::SEG_DIGITS) begin : g_used
            assign frame[8*g +: 8] = src.seg[g];
        end else begin : g_lead
            assign frame[8*g +: 8] = src.mode ? 8'h00 : dsso_pkg::SEG_ZERO;
        end
    end

    assign o_pop = emit && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= cnt_cur + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data <= frame[cnt_cur];
            r_pos  <= cnt_cur[2:0];
            r_last <= at_last;
            if (!r_busy) begin
                r_entry <= i_q_entry;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_serial_data  = r_data;
    assign o_bit_position = r_pos;
    assign o_last_bit     = r_last;

endmodule
`default_nettype wire

/* hdl/decimal_seven_segment_shift_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// Decimal seven-segment shift-out driver. Each input transfer (mode, value)
// turns into one frame of 8*DIGITS output transfers, one serial bit each, for
// a chain of DIGITS 8-bit shift registers. In show mode (mode = 0) the value
// saturates to 10^DIGITS-1 when DIGITS < 3, is split into decimal digits and
// each digit is mapped to a segment byte (segment a in bit 7, decimal point
// in bit 0, kept clear); digits above the hundreds show 0. In clear mode
// (mode = 1) every byte is zero. Bytes go out ones digit first, each byte LSB
// first; o_bit_position gives the bit's index in its byte and o_last_bit marks
// the final bit of the frame.
// The serializer sends one bit per cycle while the output is not stalled;
// frames follow each other with no gap while the queue holds the next item.
// The front classifies an item in the cycle it arrives and parks it in a
// two-entry queue, so input transfers are taken while a frame is still
// shifting out; o_stall rises only when that queue is full. With an empty
// queue and an idle serializer, an input transfer reaches the first output
// bit through the queue register, then the output register.
module decimal_seven_segment_shift_out #(
    parameter int unsigned DIGITS = 2   // 1 .. 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_value,
    // output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_serial_data,
    output logic [2:0]      o_bit_position,
    output logic            o_last_bit
);

    // front -> queue
    logic               push;
    logic               full;
    dsso_pkg::t_entry   front_entry;

    // queue -> back
    logic               pop;
    logic               q_valid;
    dsso_pkg::t_entry   q_entry;

    // Saturation and digit split; one item per transfer.
    dsso_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .i_value (i_value),
        .i_full  (full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    // Decouples input transfers from the bit stream.
    dsso_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Serializer with registered output; pulls the next item once the last bit
    // of the current frame has been sent, as it sends its first bit.
    dsso_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_entry),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_serial_data  (o_serial_data),
        .o_bit_position (o_bit_position),
        .o_last_bit     (o_last_bit)
    );

endmodule
`default_nettype wire
